/* rtl/lcft_pkg.sv */
package lcft_pkg;

  // Ring size and derived widths
  localparam int NUM_PIXELS = 12;
  localparam int PIX_W      = 6;
  localparam int ADDR_W     = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
  localparam int CFG_IDX_W  = 3;
  localparam int UPC_W      = 4;

  localparam logic [15:0] ONE_Q = 16'd256;

  typedef logic [UPC_W-1:0] upc_t;

  // One ring entry: three unsigned Q8.8 channels
  typedef struct packed {
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
  } level_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAD_PERIOD = 3'd0,
    CFG_FADE_SPAN   = 3'd1,
    CFG_FADE_RATE   = 3'd2,
    CFG_HEAD_RED    = 3'd3,
    CFG_HEAD_GREEN  = 3'd4,
    CFG_HEAD_BLUE   = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_WAIT,
    OP_MUL,
    OP_STEP,
    OP_HEAD_RD,
    OP_HEAD_WR,
    OP_FADE_CHK,
    OP_PIX_RD,
    OP_PIX_MUL,
    OP_PIX_OUT,
    OP_FADE_INC
  } op_t;

  // Jump is taken when the condition holds, else fall through to the next step
  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_NO_WRAP,
    COND_NO_FADE,
    COND_MORE_PIX
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  jump;
  } ucode_t;

  localparam upc_t UA_IDLE = 4'd0;
  localparam upc_t UA_MUL  = 4'd1;
  localparam upc_t UA_STEP = 4'd2;
  localparam upc_t UA_HRD  = 4'd3;
  localparam upc_t UA_HWR  = 4'd4;
  localparam upc_t UA_FCHK = 4'd5;
  localparam upc_t UA_PRD  = 4'd6;
  localparam upc_t UA_PMUL = 4'd7;
  localparam upc_t UA_POUT = 4'd8;
  localparam upc_t UA_FINC = 4'd9;

  function automatic ucode_t ucode_rom(upc_t addr);
    ucode_t w;
    begin
      w = '{op: OP_WAIT, cond: COND_ALWAYS, jump: UA_IDLE};
      case (addr)
        UA_IDLE: w = '{op: OP_WAIT,     cond: COND_ALWAYS,   jump: UA_MUL};
        UA_MUL:  w = '{op: OP_MUL,      cond: COND_ALWAYS,   jump: UA_STEP};
        UA_STEP: w = '{op: OP_STEP,     cond: COND_NO_WRAP,  jump: UA_FCHK};
        UA_HRD:  w = '{op: OP_HEAD_RD,  cond: COND_ALWAYS,   jump: UA_HWR};
        UA_HWR:  w = '{op: OP_HEAD_WR,  cond: COND_ALWAYS,   jump: UA_FCHK};
        UA_FCHK: w = '{op: OP_FADE_CHK, cond: COND_NO_FADE,  jump: UA_FINC};
        UA_PRD:  w = '{op: OP_PIX_RD,   cond: COND_ALWAYS,   jump: UA_PMUL};
        UA_PMUL: w = '{op: OP_PIX_MUL,  cond: COND_ALWAYS,   jump: UA_POUT};
        UA_POUT: w = '{op: OP_PIX_OUT,  cond: COND_MORE_PIX, jump: UA_PRD};
        UA_FINC: w = '{op: OP_FADE_INC, cond: COND_ALWAYS,   jump: UA_IDLE};
        default: w = '{op: OP_WAIT,     cond: COND_ALWAYS,   jump: UA_IDLE};
      endcase
      return w;
    end
  endfunction

endpackage

/* rtl/led_chase_fading_trail_top.sv */
// LED chase with a fading trail over a ring of NUM_PIXELS LEDs. Each accepted
// word with tick high is one frame: the step counter may move the head one
// place (a dark head pixel takes the head colour), and a fade pass comes every
// fade_span frames (every frame when fade_span is below two; the first one
// after reset on frame fade_span+2). A fade pass emits one output word per
// pixel, index 0 first, with last_pixel on the final one, and as it goes
// scales the lit channels by fade_rate/256.
// A word with tick low is taken and does nothing. A frame without a fade pass
// runs wait, multiply, step, fade check and fade count update, plus a head
// read and write after the step when the head moves; a fade pass adds a read,
// a multiply and an emit per pixel, stalling while the output is held off.
// The pixel store clears through per-entry valid bits, so no clearing pass
// follows reset. Configuration registers are written through cfg_we,
// cfg_index and cfg_data and should change only while the block is idle.
module led_chase_fading_trail_top
  import lcft_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 tick,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     pixel_index,
  output logic [7:0]           red,
  output logic [7:0]           green,
  output logic [7:0]           blue,
  output logic                 last_pixel
);

  localparam logic [PIX_W:0]    NUM_PIX_EXT = (PIX_W + 1)'(NUM_PIXELS);
  localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(NUM_PIXELS - 1);

  // Configuration registers
  logic [7:0] head_period;
  logic [7:0] fade_span;
  logic [7:0] fade_rate;
  logic [7:0] head_red;
  logic [7:0] head_green;
  logic [7:0] head_blue;

  // Sequencer and control state
  upc_t              upc;
  upc_t              upc_next;
  ucode_t            ctl;
  logic [15:0]       step_count;
  logic [PIX_W-1:0]  head_position;
  logic [8:0]        fade_count;
  logic [ADDR_W-1:0] pix;

  // Datapath registers
  logic [15:0] period;
  level_t      rd_data;
  logic        rd_ok;
  level_t      fade_level;
  logic        lit;
  logic [7:0]  lit_r;
  logic [7:0]  lit_g;
  logic [7:0]  lit_b;

  // Pixel store
  level_t            level [NUM_PIXELS];
  logic [NUM_PIXELS-1:0] level_ok;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  level_t            wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  logic              hold;
  logic              cond_true;
  logic              out_load;
  logic [15:0]       step_inc;
  logic              wrap;
  logic              fade_due;
  logic [PIX_W-1:0]  head_inc;
  logic              head_over;
  level_t            cur;
  logic              dark;
  logic              cur_lit;
  logic [23:0]       prod_r;
  logic [23:0]       prod_g;
  logic [23:0]       prod_b;

  assign ctl = ucode_rom(upc);

  assign in_ready = (ctl.op == OP_WAIT);
  assign out_load = (ctl.op == OP_PIX_OUT) && (!out_valid || out_ready);

  assign step_inc  = (step_count != 16'hFFFF) ? step_count + 16'd1 : step_count;
  assign wrap      = (step_inc >= period);
  assign fade_due  = (fade_count > {1'b0, fade_span});
  assign head_inc  = head_position + PIX_W'(1);
  assign head_over = ({1'b0, head_inc} >= NUM_PIX_EXT);

  assign cur     = rd_ok ? rd_data : '0;
  assign dark    = (cur.r < ONE_Q) && (cur.g < ONE_Q) && (cur.b < ONE_Q);
  assign cur_lit = (cur.r > ONE_Q) || (cur.g > ONE_Q) || (cur.b > ONE_Q);
  assign prod_r  = 24'(cur.r) * 24'(fade_rate);
  assign prod_g  = 24'(cur.g) * 24'(fade_rate);
  assign prod_b  = 24'(cur.b) * 24'(fade_rate);

  always_comb begin
    hold = 1'b0;
    if (ctl.op == OP_WAIT) begin
      hold = !(in_valid && tick);
    end else if (ctl.op == OP_PIX_OUT) begin
      hold = !out_load;
    end
  end

  always_comb begin
    unique case (ctl.cond)
      COND_ALWAYS:   cond_true = 1'b1;
      COND_NO_WRAP:  cond_true = !wrap;
      COND_NO_FADE:  cond_true = !fade_due;
      COND_MORE_PIX: cond_true = (pix != LAST_ADDR);
      default:       cond_true = 1'b1;
    endcase
  end

  always_comb begin
    if (hold) begin
      upc_next = upc;
    end else if (cond_true) begin
      upc_next = ctl.jump;
    end else begin
      upc_next = upc + upc_t'(1);
    end
  end

  // Store port selection
  assign rd_en   = (ctl.op == OP_HEAD_RD) || (ctl.op == OP_PIX_RD);
  assign rd_addr = (ctl.op == OP_HEAD_RD) ? head_position[ADDR_W-1:0] : pix;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pix;
    wr_data = fade_level;
    if (ctl.op == OP_HEAD_WR && dark) begin
      wr_en   = 1'b1;
      wr_addr = head_position[ADDR_W-1:0];
      wr_data = '{r: {head_red, 8'h00}, g: {head_green, 8'h00}, b: {head_blue, 8'h00}};
    end else if (out_load && lit) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      level[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= level[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_ok <= '0;
      rd_ok    <= 1'b0;
    end else begin
      if (wr_en) begin
        level_ok[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok <= level_ok[rd_addr];
      end
    end
  end

  // Configuration and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head_period   <= 8'd15;
      fade_span     <= 8'd5;
      fade_rate     <= 8'd246;
      head_red      <= 8'd255;
      head_green    <= 8'd0;
      head_blue     <= 8'd255;
      upc           <= UA_IDLE;
      step_count    <= '0;
      head_position <= '0;
      fade_count    <= '0;
      pix           <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HEAD_PERIOD: head_period <= cfg_data;
          CFG_FADE_SPAN:   fade_span   <= cfg_data;
          CFG_FADE_RATE:   fade_rate   <= cfg_data;
          CFG_HEAD_RED:    head_red    <= cfg_data;
          CFG_HEAD_GREEN:  head_green  <= cfg_data;
          CFG_HEAD_BLUE:   head_blue   <= cfg_data;
          default: ;
        endcase
      end

      upc <= upc_next;

      if (ctl.op == OP_STEP) begin
        if (wrap) begin
          step_count    <= '0;
          head_position <= head_over ? '0 : head_inc;
        end else begin
          step_count <= step_inc;
        end
      end

      if (ctl.op == OP_FADE_CHK && fade_due) begin
        fade_count <= 9'd1;
        pix        <= '0;
      end else if (ctl.op == OP_FADE_INC && fade_count != 9'h1FF) begin
        fade_count <= fade_count + 9'd1;
      end

      if (out_load && pix != LAST_ADDR) begin
        pix <= pix + ADDR_W'(1);
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctl.op == OP_MUL) begin
      period <= 16'(head_period) * 16'(fade_span);
    end
    if (ctl.op == OP_PIX_MUL) begin
      lit   <= cur_lit;
      lit_r <= cur_lit ? cur.r[15:8] : 8'd0;
      lit_g <= cur_lit ? cur.g[15:8] : 8'd0;
      lit_b <= cur_lit ? cur.b[15:8] : 8'd0;
      fade_level.r <= (cur.r > ONE_Q) ? prod_r[23:8] : 16'd0;
      fade_level.g <= (cur.g > ONE_Q) ? prod_g[23:8] : 16'd0;
      fade_level.b <= (cur.b > ONE_Q) ? prod_b[23:8] : 16'd0;
    end
    if (out_load) begin
      pixel_index <= PIX_W'(pix);
      red         <= lit_r;
      green       <= lit_g;
      blue        <= lit_b;
      last_pixel  <= (pix == LAST_ADDR);
    end
  end

  // Head stays inside the ring
  a_head_in_ring: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, head_position} < NUM_PIX_EXT))
    else $error("head position outside the ring");

  // A word with tick low leaves the sequencer waiting for the next word
  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !tick) |=> in_ready)
    else $error("idle tick started work");

  // The last pixel of a pass is followed by the fade counter update
  a_pass_end: assert property (@(posedge clk) disable iff (rst)
    (out_load && pix == LAST_ADDR) |=> (upc == UA_FINC))
    else $error("fade pass did not end after the last pixel");

endmodule
